// ===== hw/rtl/dda_pkg.sv =====
// Shared definitions for the decimal digit arithmetic block.
// Holds action codes, datapath operation codes and the controller command bundle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dda_pkg;

	// default operand length in decimal digits
	localparam int DIGITS_DEF = 16;

	// action codes of the input transaction
	localparam logic [2:0] ACT_LOAD_A = 3'd0;
	localparam logic [2:0] ACT_LOAD_B = 3'd1;
	localparam logic [2:0] ACT_ADD    = 3'd2;
	localparam logic [2:0] ACT_SUB    = 3'd3;
	localparam logic [2:0] ACT_MUL    = 3'd4;
	localparam logic [2:0] ACT_CLEAR  = 3'd5;

	// digit-serial operation selected for one datapath step
	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB_AB,
		OP_SUB_BA,
		OP_MUL
	} op_t;

	// command bundle from controller to datapath
	typedef struct packed {
		logic load_a;      // shift a digit into operand A
		logic load_b;      // shift a digit into operand B
		logic clear;       // zero both operands
		logic step;        // process one digit, least significant first
		op_t  op;          // operation of this step
		logic first_digit; // step works on the units digit
		logic first_pass;  // multiply: partial result is still zero
		logic rot_b;       // multiply: bring the next B digit to the top
		logic emit;        // shift the result toward the output tap
	} dda_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dda_datapath.sv =====
// Datapath of the decimal digit arithmetic block: operand shift lines,
// result shift line and a one-digit add / subtract / multiply-accumulate cell.
// Depends on dda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dda_datapath #(
	parameter int DIGITS = dda_pkg::DIGITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire dda_pkg::dda_cmd_t cmd,
	input  wire logic [3:0]       digit,
	output logic                  carry_out,
	output logic [3:0]            result_digit
);

	// operand digits, index 0 is the units place
	logic [3:0] a_q [DIGITS];
	logic [3:0] b_q [DIGITS];
	// result line: filled at the top, read at the bottom, emitted from the top
	logic [3:0] wr_q [DIGITS];
	logic [3:0] carry_q;
	logic [3:0] prev_q;

	logic [3:0] digit_clip;
	logic [3:0] cin;
	logic [3:0] shifted;
	logic [7:0] prod;
	logic [7:0] sum;
	logic [3:0] quot;
	logic [3:0] big;
	logic [3:0] small_d;
	logic [4:0] need;
	logic [3:0] digit_nx;
	logic [3:0] carry_nx;

	// quotient by ten through a reciprocal, exact for values below 100
	function automatic logic [3:0] div10(input logic [7:0] s);
		logic [15:0] p;
		p = {8'b0, s} * 16'd205;
		return p[14:11];
	endfunction

	// clip loaded digits above nine
	assign digit_clip = (digit > 4'd9) ? 4'd9 : digit;

	// carry or borrow into this digit, and the partial result times ten
	assign cin     = cmd.first_digit ? 4'd0 : carry_q;
	assign shifted = (cmd.first_digit || cmd.first_pass) ? 4'd0 : prev_q;
	assign prod    = {4'b0, b_q[DIGITS-1]} * {4'b0, a_q[0]};

	// digit cell
	always_comb begin
		sum      = 8'd0;
		quot     = 4'd0;
		need     = 5'd0;
		big      = a_q[0];
		small_d  = b_q[0];
		digit_nx = 4'd0;
		carry_nx = 4'd0;
		case (cmd.op)
			dda_pkg::OP_ADD: begin
				sum      = {4'b0, a_q[0]} + {4'b0, b_q[0]} + {4'b0, cin};
				quot     = div10(sum);
				digit_nx = 4'(sum - {quot, 3'b0} - {3'b0, quot, 1'b0});
				carry_nx = quot;
			end
			dda_pkg::OP_MUL: begin
				sum      = {4'b0, shifted} + prod + {4'b0, cin};
				quot     = div10(sum);
				digit_nx = 4'(sum - {quot, 3'b0} - {3'b0, quot, 1'b0});
				carry_nx = quot;
			end
			dda_pkg::OP_SUB_AB, dda_pkg::OP_SUB_BA: begin
				if (cmd.op == dda_pkg::OP_SUB_BA) begin
					big     = b_q[0];
					small_d = a_q[0];
				end
				need = {1'b0, small_d} + {4'b0, cin[0]};
				if ({1'b0, big} < need) begin
					digit_nx = 4'({1'b0, big} + 5'd10 - need);
					carry_nx = 4'd1;
				end else begin
					digit_nx = 4'({1'b0, big} - need);
					carry_nx = 4'd0;
				end
			end
			default: begin
				digit_nx = 4'd0;
				carry_nx = 4'd0;
			end
		endcase
	end

	assign carry_out    = carry_nx[0];
	assign result_digit = wr_q[DIGITS-1];

	// operand lines: load shifts in, steps rotate, clear zeroes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIGITS; k++) begin
				a_q[k] <= 4'd0;
				b_q[k] <= 4'd0;
			end
		end else if (cmd.clear) begin
			for (int k = 0; k < DIGITS; k++) begin
				a_q[k] <= 4'd0;
				b_q[k] <= 4'd0;
			end
		end else begin
			if (cmd.load_a) begin
				a_q[0] <= digit_clip;
				for (int k = 1; k < DIGITS; k++) a_q[k] <= a_q[k-1];
			end else if (cmd.step) begin
				a_q[DIGITS-1] <= a_q[0];
				for (int k = 0; k < DIGITS - 1; k++) a_q[k] <= a_q[k+1];
			end
			if (cmd.load_b) begin
				b_q[0] <= digit_clip;
				for (int k = 1; k < DIGITS; k++) b_q[k] <= b_q[k-1];
			end else if (cmd.rot_b) begin
				b_q[0] <= b_q[DIGITS-1];
				for (int k = 1; k < DIGITS; k++) b_q[k] <= b_q[k-1];
			end else if (cmd.step && cmd.op != dda_pkg::OP_MUL) begin
				b_q[DIGITS-1] <= b_q[0];
				for (int k = 0; k < DIGITS - 1; k++) b_q[k] <= b_q[k+1];
			end
		end
	end

	// result line and digit carry
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			carry_q <= carry_nx;
			prev_q  <= wr_q[0];
			wr_q[DIGITS-1] <= digit_nx;
			for (int k = 0; k < DIGITS - 1; k++) wr_q[k] <= wr_q[k+1];
		end else if (cmd.emit) begin
			for (int k = 1; k < DIGITS; k++) wr_q[k] <= wr_q[k-1];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/dda_ctrl.sv =====
// Controller of the decimal digit arithmetic block: sequences digit steps,
// multiply passes and the result run, and drives the command bundle.
// Depends on dda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dda_ctrl #(
	parameter int DIGITS = dda_pkg::DIGITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [2:0]        action,
	input  wire logic              carry_out,
	output dda_pkg::dda_cmd_t      cmd,
	output logic                   busy,
	output logic                   strobe,
	output logic                   swapped,
	output logic                   last
);

	localparam int CW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam logic [CW-1:0] LAST_IDX = CW'(DIGITS - 1);
	localparam logic [CW-1:0] NEXT_TO_LAST = CW'(DIGITS - 2);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_SUB1,
		S_SUB2,
		S_MUL,
		S_EMIT
	} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] pass_q;
	logic          swapped_q;
	logic          strobe_q;
	logic          last_q;
	logic          accept;

	assign accept = start && (state_q == S_IDLE);

	// decode commands from state and the accepted transaction
	always_comb begin
		cmd.load_a      = accept && (action == dda_pkg::ACT_LOAD_A);
		cmd.load_b      = accept && (action == dda_pkg::ACT_LOAD_B);
		cmd.clear       = accept && (action == dda_pkg::ACT_CLEAR);
		cmd.step        = (state_q == S_ADD) || (state_q == S_SUB1) ||
		                  (state_q == S_SUB2) || (state_q == S_MUL);
		cmd.first_digit = (cnt_q == '0);
		cmd.first_pass  = (pass_q == '0);
		cmd.rot_b       = (state_q == S_MUL) && (cnt_q == LAST_IDX);
		cmd.emit        = (state_q == S_EMIT);
		case (state_q)
			S_SUB1:  cmd.op = dda_pkg::OP_SUB_AB;
			S_SUB2:  cmd.op = dda_pkg::OP_SUB_BA;
			S_MUL:   cmd.op = dda_pkg::OP_MUL;
			default: cmd.op = dda_pkg::OP_ADD;
		endcase
	end

	// state, counters and registered result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			pass_q    <= '0;
			swapped_q <= 1'b0;
			strobe_q  <= 1'b0;
			last_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					cnt_q  <= '0;
					pass_q <= '0;
					if (start) begin
						case (action)
							dda_pkg::ACT_ADD: begin
								state_q   <= S_ADD;
								swapped_q <= 1'b0;
							end
							dda_pkg::ACT_SUB: begin
								state_q   <= S_SUB1;
								swapped_q <= 1'b0;
							end
							dda_pkg::ACT_MUL: begin
								state_q   <= S_MUL;
								swapped_q <= 1'b0;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_ADD, S_SUB2: begin
					if (cnt_q == LAST_IDX) begin
						state_q  <= S_EMIT;
						cnt_q    <= '0;
						strobe_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_SUB1: begin
					if (cnt_q == LAST_IDX) begin
						cnt_q <= '0;
						// final borrow means A was smaller: redo as B minus A
						if (carry_out) begin
							state_q   <= S_SUB2;
							swapped_q <= 1'b1;
						end else begin
							state_q  <= S_EMIT;
							strobe_q <= 1'b1;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_MUL: begin
					if (cnt_q == LAST_IDX) begin
						cnt_q <= '0;
						if (pass_q == LAST_IDX) begin
							state_q  <= S_EMIT;
							strobe_q <= 1'b1;
						end else begin
							pass_q <= pass_q + 1'b1;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_EMIT: begin
					if (cnt_q == LAST_IDX) begin
						state_q  <= S_IDLE;
						cnt_q    <= '0;
						strobe_q <= 1'b0;
						last_q   <= 1'b0;
					end else begin
						cnt_q  <= cnt_q + 1'b1;
						last_q <= (cnt_q == NEXT_TO_LAST);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy    = (state_q != S_IDLE);
	assign strobe  = strobe_q;
	assign swapped = swapped_q;
	assign last    = last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/decimal_digit_arithmetic.sv =====
// Top level of the decimal digit arithmetic block: joins controller and datapath.
// Depends on dda_pkg, dda_ctrl and dda_datapath.
//
// channel   direction  handshake              payload
// command   in         start & !busy          action, digit
// result    out        strobe                 result_digit, swapped, last
//
// Load and clear transactions complete in the accepting cycle; busy stays low.
// Add takes DIGITS digit steps, subtract DIGITS or 2*DIGITS (second pass when
// A < B), multiply DIGITS*DIGITS steps: one shared digit cell, one digit a cycle.
// Each compute transaction is followed by a run of DIGITS result digits, MSD first;
// busy stays high from acceptance through the last result.
// Reset clears both operands to zero and returns the controller to idle.
// The receiver cannot stall: each result is present for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module decimal_digit_arithmetic #(
	parameter int DIGITS = dda_pkg::DIGITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [2:0] action,
	input  wire logic [3:0] digit,
	output logic            strobe,
	output logic [3:0]      result_digit,
	output logic            swapped,
	output logic            last
);

	dda_pkg::dda_cmd_t cmd;
	logic              carry_out;

	dda_ctrl #(
		.DIGITS(DIGITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.action    (action),
		.carry_out (carry_out),
		.cmd       (cmd),
		.busy      (busy),
		.strobe    (strobe),
		.swapped   (swapped),
		.last      (last)
	);

	dda_datapath #(
		.DIGITS(DIGITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.digit        (digit),
		.carry_out    (carry_out),
		.result_digit (result_digit)
	);

	// result run stays inside the busy window
	assert property (@(posedge clk) disable iff (!arst_n) strobe |-> busy)
		else $error("result strobe outside busy");

	// a run continues until its final digit
	assert property (@(posedge clk) disable iff (!arst_n) (strobe && !last) |=> strobe)
		else $error("result run broken before last digit");

	// busy ends only right after the final digit
	assert property (@(posedge clk) disable iff (!arst_n) $fell(busy) |-> $past(last))
		else $error("busy dropped without final digit");

	// emitted digits are decimal
	assert property (@(posedge clk) disable iff (!arst_n) strobe |-> (result_digit <= 4'd9))
		else $error("result digit above nine");

endmodule

`default_nettype wire

// ===== test/dda_tb_pkg.sv =====
// Scoreboard for the decimal digit arithmetic testbench: digit-serial result predictor.
// Keeps its own copy of both operands and a queue of pending result digits.
// Depends on dda_pkg.
`timescale 1ns / 1ps

package dda_tb_pkg;

	import dda_pkg::*;

	localparam int NDIG = DIGITS_DEF;

	// one result digit as it leaves the block
	typedef struct packed {
		logic [3:0] value;
		logic       swapped;
		logic       last;
	} bcd_digit_t;

	class bcd_result_board;
		logic [3:0] opnd_a[NDIG];   // index 0 is the units digit
		logic [3:0] opnd_b[NDIG];
		bcd_digit_t due_digits[$];
		int         errors;

		function new();
			wipe_operands();
			errors = 0;
		endfunction

		function void wipe_operands();
			foreach (opnd_a[i]) begin
				opnd_a[i] = 4'd0;
				opnd_b[i] = 4'd0;
			end
		endfunction

		function int pending();
			return due_digits.size();
		endfunction

		// shift the operand up one decimal place; digits above nine load as nine
		function void shift_in(bit into_b, logic [3:0] d);
			logic [3:0] v;
			int i;
			v = (d > 4'd9) ? 4'd9 : d;
			for (i = NDIG - 1; i > 0; i--) begin
				if (into_b)
					opnd_b[i] = opnd_b[i - 1];
				else
					opnd_a[i] = opnd_a[i - 1];
			end
			if (into_b)
				opnd_b[0] = v;
			else
				opnd_a[0] = v;
		endfunction

		// compare magnitudes from the top digit down
		function bit a_below_b();
			int i;
			for (i = NDIG - 1; i >= 0; i--) begin
				if (opnd_a[i] != opnd_b[i])
					return opnd_a[i] < opnd_b[i];
			end
			return 1'b0;
		endfunction

		// apply one accepted transaction and queue the digits it produces
		function void note_command(logic [2:0] act, logic [3:0] d);
			logic [3:0]  res[NDIG];
			logic [3:0]  big[NDIG];
			logic [3:0]  sml[NDIG];
			int unsigned acc[NDIG];
			int unsigned carry;
			int unsigned s;
			int unsigned need;
			bit          swap;
			int          i;
			int          j;
			swap  = 1'b0;
			carry = 0;
			case (act)
				ACT_LOAD_A: begin
					shift_in(1'b0, d);
					return;
				end
				ACT_LOAD_B: begin
					shift_in(1'b1, d);
					return;
				end
				ACT_CLEAR: begin
					wipe_operands();
					return;
				end
				ACT_ADD: begin
					for (i = 0; i < NDIG; i++) begin
						s      = opnd_a[i] + opnd_b[i] + carry;
						res[i] = 4'(s % 10);
						carry  = s / 10;
					end
				end
				ACT_SUB: begin
					// larger minus smaller, flag when B was the larger
					swap = a_below_b();
					if (swap) begin
						big = opnd_b;
						sml = opnd_a;
					end else begin
						big = opnd_a;
						sml = opnd_b;
					end
					for (i = 0; i < NDIG; i++) begin
						need = sml[i] + carry;
						if (big[i] < need) begin
							res[i] = 4'(big[i] + 10 - need);
							carry  = 1;
						end else begin
							res[i] = 4'(big[i] - need);
							carry  = 0;
						end
					end
				end
				ACT_MUL: begin
					// sum digit products per place, then resolve carries upward
					foreach (acc[i])
						acc[i] = 0;
					for (i = 0; i < NDIG; i++)
						for (j = 0; i + j < NDIG; j++)
							acc[i + j] += opnd_a[j] * opnd_b[i];
					for (i = 0; i < NDIG; i++) begin
						s      = acc[i] + carry;
						res[i] = 4'(s % 10);
						carry  = s / 10;
					end
				end
				default: return;
			endcase
			// emit most significant digit first
			for (i = NDIG - 1; i >= 0; i--)
				due_digits.push_back('{value: res[i], swapped: swap, last: (i == 0)});
		endfunction

		// compare one strobed digit with the oldest pending one
		function void check_result(logic [3:0] v, logic sw, logic lst);
			bcd_digit_t want;
			if (due_digits.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR %0t: unexpected digit %0d swapped %0b last %0b",
						$realtime, v, sw, lst);
				return;
			end
			want = due_digits.pop_front();
			if (v !== want.value || sw !== want.swapped || lst !== want.last) begin
				errors++;
				if (errors <= 10)
					$display("ERROR %0t: digit %0d swapped %0b last %0b, expected %0d %0b %0b",
						$realtime, v, sw, lst, want.value, want.swapped, want.last);
			end
		endfunction
	endclass

endpackage

// ===== test/tb.sv =====
// Testbench top for decimal_digit_arithmetic: directed and random command streams.
// Checks every result digit against the scoreboard in dda_tb_pkg.
// Depends on dda_pkg, dda_tb_pkg and the decimal_digit_arithmetic RTL.
`timescale 1ns / 1ps

module tb;

	import dda_pkg::*;
	import dda_tb_pkg::*;

	localparam int QUIET_LIMIT  = 4000;
	localparam int RANDOM_ITEMS = 150;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [2:0] action;
	logic [3:0] digit;
	logic       strobe;
	logic [3:0] result_digit;
	logic       swapped;
	logic       last;

	int         cmds_sent;
	int         no_gap_left;
	int         target;

	bcd_result_board board = new();

	decimal_digit_arithmetic #(
		.DIGITS(NDIG)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.digit       (digit),
		.strobe      (strobe),
		.result_digit(result_digit),
		.swapped     (swapped),
		.last        (last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// note accepted transactions and check strobed digits
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				board.note_command(action, digit);
			if (strobe)
				board.check_result(result_digit, swapped, last);
		end
	end

	// end the run when nothing moves for too long
	initial begin : watchdog
		int stalled;
		stalled = 0;
		while (stalled < QUIET_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || strobe)
				stalled = 0;
			else
				stalled++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// idle cycles before the next transaction, with occasional back-to-back stretches
	function automatic int draw_gap();
		if (no_gap_left > 0) begin
			no_gap_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			no_gap_left = $urandom_range(5, 20);
		return $urandom_range(0, 7);
	endfunction

	function automatic logic [3:0] draw_digit(int style);
		case (style)
			0:       return 4'($urandom_range(0, 9));
			1:       return 4'd9;
			2:       return 4'($urandom_range(0, 15));
			default: return ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 9)) : 4'd0;
		endcase
	endfunction

	function automatic int draw_length();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return $urandom_range(0, 4);
		if (r < 8)
			return $urandom_range(5, NDIG);
		return $urandom_range(NDIG + 1, NDIG + 3);
	endfunction

	function automatic logic [2:0] draw_compute();
		case ($urandom_range(0, 2))
			0:       return ACT_ADD;
			1:       return ACT_SUB;
			default: return ACT_MUL;
		endcase
	endfunction

	// drive one transaction and hold it until the block takes it
	task automatic send_cmd(input logic [2:0] act, input logic [3:0] d);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			start <= 1'b0;
			if ($urandom_range(0, 1) == 1)
				while (busy)
					@(posedge clk);
			repeat (gap) @(posedge clk);
		end
		start  <= 1'b1;
		action <= act;
		digit  <= d;
		do
			@(posedge clk);
		while (busy);
		if (act <= ACT_CLEAR)
			cmds_sent++;
	endtask

	// build operands digit by digit, then run a few computes on them
	task automatic run_sequence();
		logic [3:0] a_seq[$];
		logic [3:0] d;
		int         style;
		int         n;
		int         i;
		bit         mirror;
		mirror = ($urandom_range(0, 7) == 0);
		if (mirror || $urandom_range(0, 2) == 0)
			send_cmd(ACT_CLEAR, draw_digit(2));
		style = $urandom_range(0, 3);
		n = draw_length();
		for (i = 0; i < n; i++) begin
			d = draw_digit(style);
			a_seq.push_back(d);
			send_cmd(ACT_LOAD_A, d);
		end
		if (mirror) begin
			foreach (a_seq[k])
				send_cmd(ACT_LOAD_B, a_seq[k]);
		end else begin
			style = $urandom_range(0, 3);
			n = draw_length();
			for (i = 0; i < n; i++)
				send_cmd(ACT_LOAD_B, draw_digit(style));
		end
		n = $urandom_range(1, 3);
		for (i = 0; i < n; i++)
			send_cmd(draw_compute(), 4'($urandom_range(0, 15)));
	endtask

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		action      = ACT_LOAD_A;
		digit       = 4'd0;
		cmds_sent   = 0;
		no_gap_left = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: zero operands, saturating loads, swapped subtract, unused actions
		send_cmd(ACT_SUB, 4'd0);
		send_cmd(ACT_LOAD_A, 4'd15);
		send_cmd(ACT_LOAD_A, 4'd12);
		send_cmd(ACT_LOAD_B, 4'd10);
		send_cmd(ACT_ADD, 4'd5);
		send_cmd(ACT_SUB, 4'd0);
		send_cmd(ACT_MUL, 4'd15);
		send_cmd(ACT_LOAD_B, 4'd0);
		send_cmd(ACT_LOAD_B, 4'd1);
		send_cmd(ACT_SUB, 4'd9);
		send_cmd(3'd6, 4'd7);
		send_cmd(3'd7, 4'd8);
		send_cmd(ACT_ADD, 4'd0);
		send_cmd(ACT_CLEAR, 4'd3);
		send_cmd(ACT_MUL, 4'd0);
		send_cmd(ACT_LOAD_A, 4'd14);
		send_cmd(ACT_LOAD_A, 4'd13);
		send_cmd(ACT_LOAD_A, 4'd11);
		send_cmd(ACT_LOAD_B, 4'd5);
		send_cmd(ACT_MUL, 4'd6);
		send_cmd(ACT_CLEAR, 4'd0);
		send_cmd(ACT_LOAD_A, 4'd7);
		send_cmd(ACT_LOAD_B, 4'd7);
		send_cmd(ACT_SUB, 4'd2);

		// random: mostly well-formed operand sequences, some loose noise
		target = cmds_sent + RANDOM_ITEMS;
		while (cmds_sent < target) begin
			if ($urandom_range(0, 9) < 7)
				run_sequence();
			else
				send_cmd(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
		end
		start <= 1'b0;

		// drain pending digits, then watch for strays
		while (board.pending() > 0)
			@(posedge clk);
		repeat (2 * NDIG + 8) @(posedge clk);

		if (board.errors == 0 && board.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
